[src/dmwu_pkg.sv]
// Package for the module-section word unpacker.
// Request payload types, result kind codes and decoder state types.
// No dependencies.
`timescale 1ns / 1ps

package dmwu_pkg;

  localparam int WordW  = 32;
  localparam int CountW = 12;
  localparam int SlotW  = 2;

  localparam logic [WordW-1:0] ALL_ONES = '1;

  // result kinds
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_VALUE  = 3'd1;
  localparam logic [2:0] KIND_STAMP  = 3'd2;
  localparam logic [2:0] KIND_DONE   = 3'd3;
  localparam logic [2:0] KIND_ABORT  = 3'd4;

  // module slots
  localparam logic [SlotW-1:0] SLOT_ADC = 2'd0;
  localparam logic [SlotW-1:0] SLOT_TDC = 2'd1;
  localparam logic [SlotW-1:0] SLOT_MCP = 2'd2;
  localparam logic [SlotW-1:0] SLOT_TOF = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SLOT = 5'b00010,
    PH_DATA = 5'b00100,
    PH_END  = 5'b01000,
    PH_SEP  = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [SlotW-1:0]   slot_idx;
    logic [CountW-1:0]  words_left;
  } walk_state_t;

  typedef struct packed {
    logic [WordW-1:0] word;
    logic             start_req;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [SlotW-1:0]  slot;
    logic [7:0]        module_id;
    logic [3:0]        resolution;
    logic [CountW-1:0] data_count;
    logic [4:0]        channel;
    logic [15:0]       sample;
    logic [29:0]       stamp;
  } out_item_t;

endpackage

[src/dmwu_decode.sv]
// Word decoder: field extraction and slot walk for one readout word.
// Purely combinational; uses dmwu_pkg.
`timescale 1ns / 1ps

module dmwu_decode (
  input  dmwu_pkg::in_item_t    item,
  input  dmwu_pkg::walk_state_t st,
  output dmwu_pkg::walk_state_t st_nxt,
  output logic                  emit,
  output dmwu_pkg::out_item_t   res
);
  import dmwu_pkg::*;

  logic              all_ones;
  logic [SlotW-1:0]  hdr_slot;
  logic [7:0]        hdr_mid;
  logic [3:0]        hdr_res;
  logic [CountW-1:0] hdr_cnt;
  logic [CountW-1:0] hdr_n;
  logic [4:0]        dat_ch;
  logic [15:0]       dat_smp;
  logic              dat_keep;
  logic [CountW-1:0] wl_dec;
  logic [29:0]       end_stamp;

  assign all_ones = (item.word == ALL_ONES);
  // a start request always restarts at the first slot
  assign hdr_slot = item.start_req ? SLOT_ADC : st.slot_idx;
  assign hdr_n    = item.word[11:0];
  assign wl_dec   = st.words_left - CountW'(1);

  always_comb begin
    hdr_mid = item.word[23:16];
    hdr_res = '0;
    hdr_cnt = (hdr_n == '0) ? '0 : hdr_n - CountW'(1);
    unique case (hdr_slot)
      SLOT_ADC: hdr_res = {1'b0, item.word[14:12]};
      SLOT_TDC: hdr_res = item.word[15:12];
      SLOT_MCP: hdr_res = '0;
      SLOT_TOF: begin
        hdr_mid = {5'b0, item.word[26:24]};
        hdr_cnt = {6'b0, item.word[13:8]};
      end
      default: hdr_res = '0;
    endcase
  end

  always_comb begin
    dat_keep = 1'b1;
    dat_ch   = item.word[20:16];
    dat_smp  = {4'b0, item.word[11:0]};
    unique case (st.slot_idx)
      SLOT_ADC: dat_smp = {3'b0, item.word[12:0]};
      SLOT_TDC: begin
        dat_smp  = item.word[15:0];
        dat_keep = ~item.word[21];  // channels 32..63 dropped
      end
      SLOT_MCP: dat_ch = item.word[20:16];
      SLOT_TOF: dat_ch = {1'b0, item.word[20:17]};
      default:  dat_ch = item.word[20:16];
    endcase
  end

  assign end_stamp = (st.slot_idx == SLOT_TOF) ? {6'b0, item.word[23:0]} : item.word[29:0];

  always_comb begin
    st_nxt = st;
    emit   = 1'b0;
    res    = '0;
    if (item.start_req || st.phase == PH_SLOT) begin
      st_nxt.slot_idx = hdr_slot;
      if (item.start_req) begin
        st_nxt.words_left = '0;
      end
      if (all_ones) begin
        st_nxt.phase = PH_SEP;
      end else begin
        st_nxt.words_left = hdr_cnt;
        st_nxt.phase      = (hdr_cnt == '0) ? PH_END : PH_DATA;
        emit              = 1'b1;
        res.kind          = KIND_HEADER;
        res.slot          = hdr_slot;
        res.module_id     = hdr_mid;
        res.resolution    = hdr_res;
        res.data_count    = hdr_cnt;
      end
    end else begin
      unique case (st.phase)
        PH_DATA: begin
          st_nxt.words_left = wl_dec;
          if (wl_dec == '0) begin
            st_nxt.phase = PH_END;
          end
          emit        = dat_keep;
          res.kind    = KIND_VALUE;
          res.slot    = st.slot_idx;
          res.channel = dat_ch;
          res.sample  = dat_smp;
        end
        PH_END: begin
          st_nxt.phase = PH_SEP;
          emit         = 1'b1;
          res.kind     = KIND_STAMP;
          res.slot     = st.slot_idx;
          res.stamp    = end_stamp;
        end
        PH_SEP: begin
          if (!all_ones) begin
            st_nxt.phase = PH_IDLE;
            emit         = 1'b1;
            res.kind     = KIND_ABORT;
            res.slot     = st.slot_idx;
          end else if (st.slot_idx == SLOT_TOF) begin
            st_nxt.phase = PH_IDLE;
            emit         = 1'b1;
            res.kind     = KIND_DONE;
            res.slot     = SLOT_TOF;
          end else begin
            st_nxt.slot_idx = st.slot_idx + SlotW'(1);
            st_nxt.phase    = PH_SLOT;
          end
        end
        default: st_nxt.phase = PH_IDLE;
      endcase
    end
  end

endmodule

[src/daq_module_word_unpacker.sv]
// Top level of the module-section word unpacker.
// Input register, dmwu_decode, walk state and result register; uses dmwu_pkg.
`timescale 1ns / 1ps

// Accepts one readout word per cycle and gives at most one result per word.
// A taken request passes through the input register and then the result
// register before out_valid rises. The walk state (slot, phase, words left)
// updates as each word leaves the input register, so a word may follow in
// every cycle; throughput drops only while the result side holds off ready.
// Words seen before a start request, and after an abort until the next start,
// give no result.
module daq_module_word_unpacker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dmwu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dmwu_pkg::out_item_t out_data
);
  import dmwu_pkg::*;

  logic        in_vld_r;
  in_item_t    in_r;
  walk_state_t st_r;
  walk_state_t st_nxt;
  logic        out_vld_r;
  out_item_t   out_r;
  logic        emit;
  out_item_t   res;
  logic        adv;

  dmwu_decode u_decode (
    .item   (in_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .emit   (emit),
    .res    (res)
  );

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r         <= 1'b0;
      out_vld_r        <= 1'b0;
      st_r.phase       <= PH_IDLE;
      st_r.slot_idx    <= '0;
      st_r.words_left  <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        st_r      <= st_nxt;
        out_vld_r <= emit;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (adv && emit) begin
      out_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[src/dmwu_checker.sv]
// Port-level checks for daq_module_word_unpacker, attached by bind.
// Uses dmwu_pkg.
`timescale 1ns / 1ps

module dmwu_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input dmwu_pkg::out_item_t out_data
);
  import dmwu_pkg::*;

  // result side must come up empty out of reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_DONE |-> out_data.slot == SLOT_TOF)
    else $error("completion not on last slot");

  a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_HEADER |->
      out_data.module_id == '0 && out_data.resolution == '0 && out_data.data_count == '0)
    else $error("header fields set on non-header result");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind == KIND_HEADER || out_data.kind == KIND_VALUE ||
      out_data.kind == KIND_STAMP || out_data.kind == KIND_DONE ||
      out_data.kind == KIND_ABORT)
    else $error("bad result kind");

endmodule

bind daq_module_word_unpacker dmwu_checker u_dmwu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
